// ===== hdl/spectral_centroid_frame_assert.svh =====
// Assertion macros for the spectral centroid block.
`ifndef SPECTRAL_CENTROID_FRAME_ASSERT_SVH
`define SPECTRAL_CENTROID_FRAME_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SCF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SCF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/scf_pkg.sv =====
package scf_pkg;

  localparam int MAG_W  = 24;             // input bin value
  localparam int AMAG_W = 24;             // |magnitude|
  localparam int HZ_W   = 24;             // bin_hz register
  localparam int ABS_W  = 37;             // abs_sum
  localparam int WSUM_W = 50;             // weighted_sum, also |weighted_sum|
  localparam int CEN_W  = 32;             // centroid
  localparam int HALF_W = WSUM_W / 2;     // multiplier operand slice
  localparam int PROD_W = HZ_W + HALF_W;  // one partial product
  localparam int NUM_W  = HZ_W + WSUM_W;  // bin_hz * |weighted_sum|
  localparam int QUO_W  = 32;             // quotient bits developed
  localparam int CNT_W  = $clog2(QUO_W);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BIN_HZ = '0;

  localparam logic [CEN_W-1:0] CEN_MAX = {1'b0, {(CEN_W-1){1'b1}}};
  localparam logic [CEN_W-1:0] CEN_MIN = {1'b1, {(CEN_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABS,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic in_ready;
    logic abs_w;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/scf_if.sv =====
interface scf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [scf_pkg::MAG_W-1:0]  magnitude;
  logic                              last_bin;

  modport source (output valid, output magnitude, output last_bin, input ready);
  modport sink   (input valid, input magnitude, input last_bin, output ready);
endinterface

interface scf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [scf_pkg::CEN_W-1:0]  centroid;

  modport source (output valid, output centroid, input ready);
  modport sink   (input valid, input centroid, output ready);
endinterface

// ===== hdl/spectral_centroid_frame.sv =====
// Spectral centroid of one frame. Magnitude bins stream in on in_ch, one
// transfer per bin starting at bin 0, last_bin set on the final bin. Bins are
// taken one per cycle while the block is idle; the block keeps a saturating sum
// of |magnitude| and of index * magnitude (index held at MAX_BINS-1 past the end).
// The last bin ends the frame: its totals go to a shared multiplier (two 24x25
// slices) and a restoring divider that develops one quotient bit per cycle, and
// the result, bin_hz * weighted / abs truncated toward zero and saturated to 32
// bits, is put in the output register. In_ch stalls from the cycle after the
// last bin is taken until the result is in the output register, through the
// input pipeline register and the abs, two multiply, sum, divide and load steps;
// the load waits until the previous result has been taken. A silent frame or
// bin_hz of 0 gives 0. bin_hz lies at byte address 0 of the APB-style port;
// write it only while the block is idle.
`include "spectral_centroid_frame_assert.svh"

module spectral_centroid_frame #(
  parameter int MAX_BINS = 4097
) (
  input  logic                           clk,
  input  logic                           rst_n,
  scf_in_if.sink                         in_ch,
  scf_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [scf_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [scf_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [scf_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                           cfg_pready
);
  import scf_pkg::*;

  ctrl_cmd_t          cmd;
  dp_stat_t           stat;
  logic [HZ_W-1:0]    bin_hz_r;
  logic               cfg_sel_hz;

  // config register: single access-phase write, zero wait states
  assign cfg_pready = 1'b1;
  assign cfg_sel_hz = (cfg_paddr[ADDR_W-1:2] == REG_BIN_HZ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_hz_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_hz) begin
      bin_hz_r <= cfg_pwdata[HZ_W-1:0];
    end
  end

  assign cfg_prdata = cfg_sel_hz ? DATA_W'(bin_hz_r) : '0;

  scf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  scf_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .bin_hz       (bin_hz_r),
    .in_valid     (in_ch.valid),
    .in_magnitude (in_ch.magnitude),
    .in_last_bin  (in_ch.last_bin),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_centroid (out_ch.centroid)
  );

  // input stalls while the divider owns a frame
  assign in_ch.ready = cmd.in_ready;

  // a frame end must find the divider free, and start it
  `SCF_ASSERT_IMP(a_end_idle, clk, rst_n, stat.frame_done, !cmd.busy, "frame end while busy")
  `SCF_ASSERT_NXT(a_end_start, clk, rst_n, stat.frame_done, cmd.busy, "divider not started")
  // never overwrite a result that is still waiting
  `SCF_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load_out, !out_ch.valid || out_ch.ready, "result lost")

endmodule

// ===== hdl/scf_ctrl.sv =====
module scf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  scf_pkg::dp_stat_t  stat,
  output scf_pkg::ctrl_cmd_t cmd
);
  import scf_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE:   if (stat.frame_done) state_nxt = S_ABS;
      S_ABS:    state_nxt = S_MUL_LO;
      S_MUL_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_SUM;
      S_SUM: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) state_nxt = S_OUT;
      end
      S_OUT:    if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.busy     = (state_r != S_IDLE);
    cmd.in_ready = (state_r == S_IDLE) && !stat.frame_done;
    unique case (state_r)
      S_IDLE:   ;
      S_ABS:    cmd.abs_w    = 1'b1;
      S_MUL_LO: cmd.mul_lo   = 1'b1;
      S_MUL_HI: cmd.mul_hi   = 1'b1;
      S_SUM:    cmd.sum      = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_OUT:    cmd.load_out = stat.out_free;
      default:  ;
    endcase
  end

endmodule

// ===== hdl/scf_dp.sv =====
module scf_dp #(
  parameter int MAX_BINS = 4097
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  scf_pkg::ctrl_cmd_t                cmd,
  output scf_pkg::dp_stat_t                 stat,
  input  logic [scf_pkg::HZ_W-1:0]          bin_hz,
  input  logic                              in_valid,
  input  logic signed [scf_pkg::MAG_W-1:0]  in_magnitude,
  input  logic                              in_last_bin,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [scf_pkg::CEN_W-1:0]  out_centroid
);
  import scf_pkg::*;

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int WP_W  = IDX_W + MAG_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BINS - 1);
  localparam logic signed [WSUM_W-1:0] WSUM_MAX = {1'b0, {(WSUM_W-1){1'b1}}};
  localparam logic signed [WSUM_W-1:0] WSUM_MIN = {1'b1, {(WSUM_W-1){1'b0}}};

  logic                     accept;
  logic [IDX_W-1:0]         idx_r;
  logic                     s1_valid_r, s1_last_r;
  logic signed [WP_W-1:0]   s1_prod_r;
  logic [AMAG_W-1:0]        s1_amag_r;
  logic signed [WP_W-1:0]   prod;
  logic [AMAG_W-1:0]        amag;

  logic [ABS_W-1:0]         abs_sum_r;
  logic signed [WSUM_W-1:0] wsum_r;
  logic [ABS_W:0]           abs_tmp;
  logic [ABS_W-1:0]         abs_nxt;
  logic signed [WSUM_W:0]   w_tmp;
  logic signed [WSUM_W-1:0] wsum_nxt;

  logic [ABS_W-1:0]         dabs_r;
  logic signed [WSUM_W-1:0] dw_r;
  logic                     neg_r;
  logic [WSUM_W-1:0]        wmag_r;
  logic [HALF_W-1:0]        mul_op;
  logic [PROD_W-1:0]        mul_p;
  logic [PROD_W-1:0]        p_lo_r, p_hi_r;
  logic [NUM_W-1:0]         num;
  logic                     ovf_r;
  logic [ABS_W-1:0]         rem_r;
  logic [QUO_W-1:0]         quo_r;
  logic [ABS_W:0]           rem_sh;
  logic                     rem_ge;
  logic [CEN_W-1:0]         result;
  logic                     out_valid_r;
  logic [CEN_W-1:0]         out_cen_r;

  assign accept = in_valid && cmd.in_ready;

  // stage 1: index product and absolute value
  assign prod = $signed({1'b0, idx_r}) * in_magnitude;
  assign amag = in_magnitude[MAG_W-1] ? AMAG_W'(-in_magnitude) : AMAG_W'(in_magnitude);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        if (in_last_bin)         idx_r <= '0;
        else if (idx_r < IDX_LAST) idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod_r <= prod;
      s1_amag_r <= amag;
      s1_last_r <= in_last_bin;
    end
  end

  // stage 2: saturating accumulation
  assign abs_tmp = {1'b0, abs_sum_r} + (ABS_W + 1)'(s1_amag_r);
  assign abs_nxt = abs_tmp[ABS_W] ? {ABS_W{1'b1}} : abs_tmp[ABS_W-1:0];
  assign w_tmp   = {wsum_r[WSUM_W-1], wsum_r}
                 + {{(WSUM_W + 1 - WP_W){s1_prod_r[WP_W-1]}}, s1_prod_r};

  always_comb begin
    if (w_tmp[WSUM_W] != w_tmp[WSUM_W-1]) begin
      wsum_nxt = w_tmp[WSUM_W] ? WSUM_MIN : WSUM_MAX;
    end else begin
      wsum_nxt = w_tmp[WSUM_W-1:0];
    end
  end

  assign stat.frame_done = s1_valid_r && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_sum_r <= '0;
      wsum_r    <= '0;
    end else if (s1_valid_r) begin
      abs_sum_r <= s1_last_r ? '0 : abs_nxt;
      wsum_r    <= s1_last_r ? '0 : wsum_nxt;
    end
  end

  // frame totals handed to the divider
  always_ff @(posedge clk) begin
    if (stat.frame_done) begin
      dabs_r <= abs_nxt;
      dw_r   <= wsum_nxt;
    end
  end

  // |weighted_sum| times bin_hz, two slices through one multiplier
  assign mul_op = cmd.mul_hi ? wmag_r[WSUM_W-1:HALF_W] : wmag_r[HALF_W-1:0];
  assign mul_p  = bin_hz * mul_op;
  assign num    = NUM_W'(p_lo_r) + (NUM_W'(p_hi_r) << HALF_W);

  // restoring division, one quotient bit per step
  assign rem_sh = {rem_r, quo_r[QUO_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dabs_r};

  always_ff @(posedge clk) begin
    if (cmd.abs_w) begin
      neg_r  <= dw_r[WSUM_W-1];
      wmag_r <= dw_r[WSUM_W-1] ? WSUM_W'(-dw_r) : WSUM_W'(dw_r);
    end
    if (cmd.mul_lo) p_lo_r <= mul_p;
    if (cmd.mul_hi) p_hi_r <= mul_p;
    if (cmd.sum) begin
      ovf_r <= num[NUM_W-1:QUO_W] >= (NUM_W - QUO_W)'(dabs_r);
      rem_r <= num[QUO_W+ABS_W-1:QUO_W];
      quo_r <= num[QUO_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? ABS_W'(rem_sh - {1'b0, dabs_r}) : rem_sh[ABS_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], rem_ge};
    end
  end

  always_comb begin
    if (dabs_r == '0) begin
      result = '0;
    end else if (ovf_r || quo_r[QUO_W-1]) begin
      result = neg_r ? CEN_MIN : CEN_MAX;
    end else begin
      result = neg_r ? CEN_W'(-quo_r) : CEN_W'(quo_r);
    end
  end

  // output register
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_cen_r <= result;
  end

  assign out_valid    = out_valid_r;
  assign out_centroid = out_cen_r;

endmodule
